### rtl/frame_rate_digit_overlay_assert.svh
// Assertion macros for the frame rate digit overlay checker.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef FRAME_RATE_DIGIT_OVERLAY_ASSERT_SVH
`define FRAME_RATE_DIGIT_OVERLAY_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FRDO_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define FRDO_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/frdo_pkg.sv
// Shared types, constants and the glyph function of the frame rate digit overlay.
// No dependencies.
package frdo_pkg;

    localparam int unsigned RATE_SCALE  = 1000000;
    localparam int unsigned GLYPH_W     = 15;
    localparam int unsigned X_W         = 10;
    localparam int unsigned STAMP_W     = 32;
    localparam logic [X_W-1:0] X_RESET  = 10'd316;
    localparam logic [X_W-1:0] X_STEP   = 10'd4;

    // q / 10 == (q * RECIP_10) >> RECIP_SHIFT, exact for any 32-bit q
    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int unsigned RECIP_SHIFT = 35;

    localparam logic [6:0] SEG_CODE [10] = '{
        7'o167, 7'o044, 7'o135, 7'o155, 7'o056,
        7'o153, 7'o173, 7'o045, 7'o177, 7'o157
    };

    // segments that light each pixel, bit row*3+col
    localparam logic [6:0] PIX_SEG [GLYPH_W] = '{
        7'o003, 7'o001, 7'o005, 7'o002, 7'o000,
        7'o004, 7'o032, 7'o010, 7'o054, 7'o020,
        7'o000, 7'o040, 7'o120, 7'o100, 7'o140
    };

    typedef struct packed {
        logic load;
        logic ring_wr;
        logic div_init;
        logic div_step;
        logic mul;
        logic emit;
    } frdo_cmd_t;

    typedef struct packed {
        logic old_ok;
        logic div_last;
        logic q_next_zero;
        logic out_free;
        logic digit_last;
    } frdo_status_t;

    function automatic logic [GLYPH_W-1:0] glyph_of(input logic [3:0] d);
        logic [6:0]         seg;
        logic [GLYPH_W-1:0] mask;
        seg  = (d < 4'd10) ? SEG_CODE[d] : 7'd0;
        mask = '0;
        for (int i = 0; i < GLYPH_W; i++)
        begin
            mask[i] = |(seg & PIX_SEG[i]);
        end
        return mask;
    endfunction

endpackage

### rtl/frdo_ctrl.sv
// Sequencer of the frame rate digit overlay: ring access, division, digit steps.
// Depends on frdo_pkg for the command and status structs.
module frdo_ctrl
    import frdo_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         enabled,
    output logic         in_ready,
    input  frdo_status_t status,
    output frdo_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_MUL,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                // a disabled transaction is taken and dropped
                if (in_valid && enabled)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.ring_wr = 1'b1;
                if (status.old_ok)
                begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = status.q_next_zero ? S_IDLE : S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = status.digit_last ? S_IDLE : S_MUL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= (state_next == S_IDLE);
        end
    end

    assign in_ready = in_ready_reg;

endmodule

### rtl/frdo_datapath.sv
// Datapath of the frame rate digit overlay: stamp ring, restoring divider,
// divide-by-ten digit unit, output register. Depends on frdo_pkg.
module frdo_datapath
    import frdo_pkg::*;
#(
    parameter int unsigned WINDOW_FRAMES = 16,
    parameter int unsigned MAX_DIGITS    = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  frdo_cmd_t            cmd,
    output frdo_status_t         status,
    input  logic [STAMP_W-1:0]   time_stamp,
    input  logic                 cfg_we,
    input  logic [X_W-1:0]       cfg_wdata,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [3:0]           digit_value,
    output logic [X_W-1:0]       digit_x,
    output logic [GLYPH_W-1:0]   glyph_pixels,
    output logic                 last_digit
);

    localparam int unsigned DIVIDEND = WINDOW_FRAMES * RATE_SCALE;
    localparam int unsigned DW       = $clog2(DIVIDEND + 1);
    localparam int unsigned BW       = $clog2(DW);
    localparam int unsigned IW       = $clog2(WINDOW_FRAMES);
    localparam int unsigned CW       = $clog2(MAX_DIGITS + 1);
    localparam logic [DW-1:0] DIVIDEND_V = DW'(DIVIDEND);

    // stamp ring
    logic [STAMP_W-1:0]       ring_mem [WINDOW_FRAMES];
    logic [WINDOW_FRAMES-1:0] ring_vld_reg;
    logic [IW-1:0]            idx_reg;
    logic [STAMP_W-1:0]       rd_q_reg;
    logic                     rd_vld_reg;
    logic [STAMP_W-1:0]       stamp_reg;
    logic [STAMP_W-1:0]       old_stamp;

    // divider and digit unit
    logic [STAMP_W-1:0]       div_reg;
    logic [STAMP_W-1:0]       rem_reg;
    logic [BW-1:0]            bit_cnt_reg;
    logic [DW-1:0]            q_reg;
    logic [DW-1:0]            quot_reg;
    logic [CW-1:0]            dcnt_reg;
    logic [X_W-1:0]           x_reg;
    logic [X_W-1:0]           right_digit_x_reg;
    logic [STAMP_W:0]         trial;
    logic                     trial_ge;
    logic [STAMP_W-1:0]       rem_next;
    logic [DW-1:0]            q_next;
    logic [63:0]              recip_prod;
    logic [DW-1:0]            quot_times10;
    logic [DW-1:0]            digit_full;
    logic [3:0]               digit;

    // output register
    logic                     out_valid_reg;
    logic [3:0]               digit_value_reg;
    logic [X_W-1:0]           digit_x_reg;
    logic [GLYPH_W-1:0]       glyph_reg;
    logic                     last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rd_q_reg <= ring_mem[idx_reg];
        end
        if (cmd.ring_wr)
        begin
            ring_mem[idx_reg] <= stamp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_vld_reg <= '0;
            rd_vld_reg   <= 1'b0;
            idx_reg      <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                rd_vld_reg <= ring_vld_reg[idx_reg];
            end
            if (cmd.ring_wr)
            begin
                ring_vld_reg[idx_reg] <= 1'b1;
                idx_reg <= (idx_reg == IW'(WINDOW_FRAMES - 1)) ? '0 : idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            stamp_reg <= time_stamp;
        end
    end

    // a never-written slot reads as zero, i.e. empty
    assign old_stamp = rd_vld_reg ? rd_q_reg : '0;

    // one restoring step: remainder stays below the divisor
    assign trial    = {rem_reg, DIVIDEND_V[bit_cnt_reg]};
    assign trial_ge = (trial >= {1'b0, div_reg});
    assign rem_next = trial_ge ? STAMP_W'(trial - {1'b0, div_reg}) : trial[STAMP_W-1:0];
    assign q_next   = {q_reg[DW-2:0], trial_ge};

    assign recip_prod   = {{(32 - DW){1'b0}}, q_reg} * RECIP_10;
    assign quot_times10 = (quot_reg << 3) + (quot_reg << 1);
    assign digit_full   = q_reg - quot_times10;
    assign digit        = digit_full[3:0];

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            div_reg     <= stamp_reg - old_stamp;
            rem_reg     <= '0;
            bit_cnt_reg <= BW'(DW - 1);
            q_reg       <= '0;
            dcnt_reg    <= '0;
            x_reg       <= right_digit_x_reg;
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= rem_next;
            q_reg       <= q_next;
            bit_cnt_reg <= bit_cnt_reg - 1'b1;
        end
        else if (cmd.emit)
        begin
            q_reg    <= quot_reg;
            x_reg    <= x_reg - X_STEP;
            dcnt_reg <= dcnt_reg + 1'b1;
        end
        if (cmd.mul)
        begin
            quot_reg <= recip_prod[RECIP_SHIFT +: DW];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            right_digit_x_reg <= X_RESET;
        end
        else if (cfg_we)
        begin
            right_digit_x_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            digit_value_reg <= digit;
            digit_x_reg     <= x_reg;
            glyph_reg       <= glyph_of(digit);
            last_reg        <= status.digit_last;
        end
    end

    always_comb
    begin
        status             = '0;
        status.old_ok      = (old_stamp != '0) && (stamp_reg != old_stamp);
        status.div_last    = (bit_cnt_reg == '0);
        status.q_next_zero = (q_next == '0);
        status.out_free    = !out_valid_reg || out_ready;
        status.digit_last  = (quot_reg == '0) || (dcnt_reg == CW'(MAX_DIGITS - 1));
    end

    assign out_valid    = out_valid_reg;
    assign digit_value  = digit_value_reg;
    assign digit_x      = digit_x_reg;
    assign glyph_pixels = glyph_reg;
    assign last_digit   = last_reg;

endmodule

### rtl/frame_rate_digit_overlay.sv
// Frame rate meter with digit overlay. Depends on frdo_pkg, frdo_ctrl, frdo_datapath.
// Flow: the stamp is loaded and its ring slot read; the slot is then written, and a
// restoring division runs over the dividend bits (24 at the default window); each digit
// then takes a reciprocal multiply and an emit, which waits while the output is held.
// A new frame waits for the last digit; a disabled frame is dropped, an empty or equal slot gives none.
// Reset clears the stamp ring valid bits and index at once; right_digit_x resets to 316.
module frame_rate_digit_overlay
    import frdo_pkg::*;
#(
    parameter int unsigned WINDOW_FRAMES = 16,
    parameter int unsigned MAX_DIGITS    = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 enabled,
    input  logic [STAMP_W-1:0]   time_stamp,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [3:0]           digit_value,
    output logic [X_W-1:0]       digit_x,
    output logic [GLYPH_W-1:0]   glyph_pixels,
    output logic                 last_digit,
    input  logic                 cfg_we,
    input  logic [X_W-1:0]       cfg_wdata
);

    frdo_cmd_t    cmd;
    frdo_status_t status;

    frdo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .enabled  (enabled),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    frdo_datapath #(
        .WINDOW_FRAMES (WINDOW_FRAMES),
        .MAX_DIGITS    (MAX_DIGITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .time_stamp   (time_stamp),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .digit_value  (digit_value),
        .digit_x      (digit_x),
        .glyph_pixels (glyph_pixels),
        .last_digit   (last_digit)
    );

endmodule

### rtl/frdo_checker.sv
// Port-level checker for frame_rate_digit_overlay, with its bind statement.
// Depends on frdo_pkg and frame_rate_digit_overlay_assert.svh.
`include "frame_rate_digit_overlay_assert.svh"

module frdo_checker
    import frdo_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [3:0]         digit_value,
    input logic [GLYPH_W-1:0] glyph_pixels,
    input logic               last_digit
);

    // a stalled digit transaction holds
    `FRDO_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(digit_value), "digit changed while stalled")

    `FRDO_ASSERT_IMP(a_digit_range, out_valid, digit_value <= 4'd9, "digit out of decimal range")

    `FRDO_ASSERT_IMP(a_glyph_match, out_valid, glyph_pixels == glyph_of(digit_value), "glyph does not match digit")

    // no new frame is taken while a run of digits is unfinished
    `FRDO_ASSERT_IMP(a_run_blocks_input, out_valid && !last_digit, !in_ready, "input ready mid digit run")

endmodule

bind frame_rate_digit_overlay frdo_checker u_frdo_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .digit_value  (digit_value),
    .glyph_pixels (glyph_pixels),
    .last_digit   (last_digit)
);

### bench/frame_rate_digit_overlay_test.sv
// Self-checking bench for frame_rate_digit_overlay: random frame timing, random stalls.
// Depends on frdo_pkg and the frame_rate_digit_overlay RTL; nothing else.
`timescale 1ns / 1ps

module frame_rate_digit_overlay_test;
    import frdo_pkg::*;

    localparam int unsigned FRAME_WINDOW  = 16;
    localparam int unsigned DIGIT_LIMIT   = 8;
    localparam logic [31:0] RATE_NUMER    = 32'd16000000;
    localparam int unsigned SETTLE_CYCLES = 60;
    localparam int unsigned STALL_LIMIT   = 4000;

    // 3x5 font, rows bottom to top, each row col2..col0
    localparam logic [GLYPH_W-1:0] DIGIT_FONT [10] = '{
        15'b111_101_101_101_111,
        15'b100_100_100_100_100,
        15'b111_001_111_100_111,
        15'b111_100_111_100_111,
        15'b100_100_111_101_101,
        15'b111_100_111_001_111,
        15'b111_101_111_001_111,
        15'b100_100_100_100_111,
        15'b111_101_111_101_111,
        15'b111_100_111_101_111
    };

    typedef struct packed {
        logic               enabled;
        logic [STAMP_W-1:0] stamp;
    } frame_item_t;

    typedef struct packed {
        logic [3:0]         value;
        logic [X_W-1:0]     pos_x;
        logic [GLYPH_W-1:0] glyph;
        logic               is_last;
    } digit_cell_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 enabled = 1'b0;
    logic [STAMP_W-1:0]   time_stamp = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b1;
    logic [3:0]           digit_value;
    logic [X_W-1:0]       digit_x;
    logic [GLYPH_W-1:0]   glyph_pixels;
    logic                 last_digit;
    logic                 cfg_we = 1'b0;
    logic [X_W-1:0]       cfg_wdata = '0;

    frame_item_t          pending_frames [$];
    digit_cell_t          due_digits [$];

    // mirror of the block state
    logic [STAMP_W-1:0]   frame_stamps [FRAME_WINDOW];
    int unsigned          stamp_slot = 0;
    logic [X_W-1:0]       overlay_x = X_RESET;

    logic                 steady = 1'b0;
    int unsigned          send_gap = 0;
    int unsigned          recv_gap = 0;
    int unsigned          quiet_cycles = 0;
    int unsigned          fault_count = 0;
    int unsigned          frames_taken = 0;
    int unsigned          frames_enabled = 0;
    int unsigned          digits_checked = 0;
    int unsigned          edge_settings = 0;

    frame_rate_digit_overlay #(
        .WINDOW_FRAMES (FRAME_WINDOW),
        .MAX_DIGITS    (DIGIT_LIMIT)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .enabled      (enabled),
        .time_stamp   (time_stamp),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .digit_value  (digit_value),
        .digit_x      (digit_x),
        .glyph_pixels (glyph_pixels),
        .last_digit   (last_digit),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    always #6 clk = ~clk;

    // Expected digits for one accepted frame event.
    function automatic void measure_frame(input logic en, input logic [STAMP_W-1:0] now);
        logic [STAMP_W-1:0] oldest;
        logic [31:0]        rate;
        logic [X_W-1:0]     cell_x;
        int unsigned        emitted;
        digit_cell_t        entry;
        if (!en)
            return;
        frames_enabled++;
        oldest = frame_stamps[stamp_slot];
        if (oldest != '0 && now != oldest)
        begin
            rate    = RATE_NUMER / (now - oldest);
            cell_x  = overlay_x;
            emitted = 0;
            while (rate != 0 && emitted < DIGIT_LIMIT)
            begin
                entry.value   = 4'(rate % 10);
                entry.pos_x   = cell_x;
                entry.glyph   = DIGIT_FONT[rate % 10];
                rate          = rate / 10;
                emitted++;
                entry.is_last = (rate == 0) || (emitted == DIGIT_LIMIT);
                due_digits.push_back(entry);
                cell_x        = cell_x - X_STEP;
            end
        end
        frame_stamps[stamp_slot] = now;
        stamp_slot = (stamp_slot + 1) % FRAME_WINDOW;
    endfunction

    // Driver: one frame transaction at a time, a random gap after each outside the steady pass.
    always @(posedge clk)
    begin
        frame_item_t nxt;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                measure_frame(enabled, time_stamp);
                frames_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_frames.size() != 0)
                begin
                    nxt        = pending_frames.pop_front();
                    enabled    <= nxt.enabled;
                    time_stamp <= nxt.stamp;
                    in_valid   <= 1'b1;
                    send_gap   <= steady ? 0 : $urandom_range(0, 15);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each digit transaction; outside the steady pass it stalls ready while valid is up.
    always @(posedge clk)
    begin
        digit_cell_t want;
        int unsigned stall;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                digits_checked++;
                if (due_digits.size() == 0)
                begin
                    if (fault_count < 10)
                        $display("unexpected digit: value %0d x %0d glyph %h last %0d",
                                 digit_value, digit_x, glyph_pixels, last_digit);
                    fault_count++;
                end
                else
                begin
                    want = due_digits.pop_front();
                    if (digit_value !== want.value || digit_x !== want.pos_x ||
                        glyph_pixels !== want.glyph || last_digit !== want.is_last)
                    begin
                        if (fault_count < 10)
                        begin
                            $display("digit mismatch: expected value %0d x %0d glyph %h last %0d",
                                     want.value, want.pos_x, want.glyph, want.is_last);
                            $display("                got value %0d x %0d glyph %h last %0d",
                                     digit_value, digit_x, glyph_pixels, last_digit);
                        end
                        fault_count++;
                    end
                end
                stall     = steady ? 0 : $urandom_range(0, 15);
                recv_gap  <= stall;
                out_ready <= (stall == 0);
            end
            else if (out_valid && recv_gap != 0)
            begin
                recv_gap  <= recv_gap - 1;
                out_ready <= (recv_gap == 1);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("[frame_rate_digit_overlay] ERROR");
        $finish;
    end

    // Block is idle once all frames are in, all digits out, and any silent frame is done.
    task automatic wait_idle();
        while (pending_frames.size() != 0 || in_valid || due_digits.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_right_edge(input logic [X_W-1:0] edge_x);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= edge_x;
        @(posedge clk);
        cfg_we    <= 1'b0;
        overlay_x = edge_x;
        edge_settings++;
    endtask

    // Mostly steady frame runs with jitter; some disabled, zero and random stamps.
    // Every queued transaction counts toward the target.
    task automatic queue_frames(input int unsigned target);
        int unsigned        queued;
        int unsigned        kind;
        int unsigned        period;
        int unsigned        jitter;
        logic [STAMP_W-1:0] clock_ms;
        queued = 0;
        while (queued < target)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 80)
            begin
                case ($urandom_range(0, 4))
                    0:       begin period = 0;       jitter = 1;       end
                    1:       begin period = 16;      jitter = 20;      end
                    2:       begin period = 30;      jitter = 2000;    end
                    3:       begin period = 60000;   jitter = 1000000; end
                    default: begin period = 1000000; jitter = 4000000; end
                endcase
                clock_ms = ($urandom_range(0, 3) == 0) ?
                           32'hFFFF_FFFF - $urandom_range(0, 2000) : $urandom;
                repeat ($urandom_range(18, 40))
                begin
                    if (queued < target)
                    begin
                        clock_ms = clock_ms + period + $urandom_range(0, jitter);
                        if ($urandom_range(0, 15) == 0)
                        begin
                            pending_frames.push_back(frame_item_t'{1'b0, clock_ms});
                            queued++;
                        end
                        pending_frames.push_back(frame_item_t'{1'b1, clock_ms});
                        queued++;
                    end
                end
            end
            else if (kind < 88)
            begin
                pending_frames.push_back(frame_item_t'{1'b0, $urandom});
                queued++;
            end
            else if (kind < 92)
            begin
                pending_frames.push_back(frame_item_t'{1'b1, 32'h0});
                queued++;
            end
            else
            begin
                pending_frames.push_back(frame_item_t'{1'b1, $urandom});
                queued++;
            end
        end
    endtask

    initial
    begin
        logic [X_W-1:0] edges [5];
        for (int k = 0; k < FRAME_WINDOW; k++)
            frame_stamps[k] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: fill the ring, then hit each corner once.
        set_right_edge(10'd1023);
        pending_frames.push_back(frame_item_t'{1'b0, 32'hFFFF_FFFF});
        pending_frames.push_back(frame_item_t'{1'b1, 32'h0000_0000});
        pending_frames.push_back(frame_item_t'{1'b1, 32'h0000_1000});
        pending_frames.push_back(frame_item_t'{1'b1, 32'h0000_2000});
        pending_frames.push_back(frame_item_t'{1'b1, 32'h0000_3000});
        pending_frames.push_back(frame_item_t'{1'b1, 32'hFFFF_FFF0});
        pending_frames.push_back(frame_item_t'{1'b1, 32'h0123_4567});
        for (int k = 6; k < FRAME_WINDOW; k++)
            pending_frames.push_back(frame_item_t'{1'b1, 32'h0001_0000 + k * 1000});
        pending_frames.push_back(frame_item_t'{1'b1, 32'hFFFF_FFFF});   // zero slot: empty
        pending_frames.push_back(frame_item_t'{1'b1, 32'h0000_1001});   // 1 ms: eight digits
        pending_frames.push_back(frame_item_t'{1'b1, 32'h0000_2000});   // same stamp
        pending_frames.push_back(frame_item_t'{1'b1, 32'h0000_3000 + RATE_NUMER + 1});
        pending_frames.push_back(frame_item_t'{1'b1, 32'h0000_0010});   // wraps through zero
        pending_frames.push_back(frame_item_t'{1'b0, 32'hAAAA_5555});
        pending_frames.push_back(frame_item_t'{1'b1, 32'h0123_4567 + RATE_NUMER});
        pending_frames.push_back(frame_item_t'{1'b1, 32'h0001_1773});
        wait_idle();

        // below 28 the leftmost cells wrap around the 10-bit x range
        edges = '{10'd28, 10'd3, X_RESET, 10'($urandom_range(28, 1023)), 10'd1023};
        for (int p = 0; p < 5; p++)
        begin
            set_right_edge(edges[p]);
            steady = (p == 2);
            queue_frames(41);
            wait_idle();
        end

        if (due_digits.size() != 0)
        begin
            $display("%0d expected digits never arrived", due_digits.size());
            fault_count++;
        end
        $display("frames accepted %0d (%0d enabled), digits checked %0d, right edges set %0d",
                 frames_taken, frames_enabled, digits_checked, edge_settings);
        $display("failures %0d", fault_count);
        if (fault_count == 0)
            $display("[frame_rate_digit_overlay] OK");
        else
            $display("[frame_rate_digit_overlay] ERROR");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/frdo_pkg.sv
rtl/frdo_ctrl.sv
rtl/frdo_datapath.sv
rtl/frame_rate_digit_overlay.sv
rtl/frdo_checker.sv
bench/frame_rate_digit_overlay_test.sv
